[design/fsc_pkg.sv]
// Shared types and constants for the file signature carver.
`default_nettype none

package fsc_pkg;

	localparam int OFF_W = 48;
	localparam int CFG_W = 32;
	localparam int LEN_W = 3;

	localparam logic [CFG_W-1:0] MAX_LEN_RESET = 32'd16777216;

	// Header lengths in bytes
	localparam logic [LEN_W-1:0] JPEG_HEAD_LEN = 3'd3;
	localparam logic [LEN_W-1:0] PDF_HEAD_LEN  = 3'd5;
	localparam logic [LEN_W-1:0] ZIP_HEAD_LEN  = 3'd4;

	// ZIP end-of-central-directory: 4 byte marker, record is 22 bytes long
	localparam int ZIP_MARK_LEN = 4;
	localparam int ZIP_TAIL_LEN = 22;
	localparam logic [OFF_W-1:0] ZIP_END_ADD = OFF_W'(ZIP_TAIL_LEN - ZIP_MARK_LEN);

	localparam logic [7:0] CH_FF      = 8'hFF;
	localparam logic [7:0] CH_D8      = 8'hD8;
	localparam logic [7:0] CH_D9      = 8'hD9;
	localparam logic [7:0] CH_PCT     = 8'h25;
	localparam logic [7:0] CH_P       = 8'h50;
	localparam logic [7:0] CH_D       = 8'h44;
	localparam logic [7:0] CH_F       = 8'h46;
	localparam logic [7:0] CH_DASH    = 8'h2D;
	localparam logic [7:0] CH_E       = 8'h45;
	localparam logic [7:0] CH_O       = 8'h4F;
	localparam logic [7:0] CH_K       = 8'h4B;
	localparam logic [7:0] CH_03      = 8'h03;
	localparam logic [7:0] CH_04      = 8'h04;
	localparam logic [7:0] CH_05      = 8'h05;
	localparam logic [7:0] CH_06      = 8'h06;

	typedef enum logic [1:0] {
		KIND_JPEG = 2'd0,
		KIND_PDF  = 2'd1,
		KIND_ZIP  = 2'd2
	} fsc_kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_image;
	} fsc_item_t;

	typedef struct packed {
		logic [OFF_W-1:0] start_offset;
		logic [OFF_W-1:0] end_offset;
		logic [1:0]       file_kind;
		logic             last_of_run;
		logic             overflow_seen;
	} fsc_result_t;

	// One classified byte handed from the scanner to the slot engine
	typedef struct packed {
		logic [OFF_W-1:0] next_offset;
		logic             end_hit;
		fsc_kind_t        end_kind;
		logic [OFF_W-1:0] end_offset;
		logic             head_hit;
		fsc_kind_t        head_kind;
		logic [LEN_W-1:0] head_len;
		logic [OFF_W-1:0] head_start;
		logic             last_byte;
	} fsc_event_t;

endpackage

`default_nettype wire

[design/fsc_scan.sv]
// Front end: byte window, offset counter and marker detection.
`default_nettype none

module fsc_scan (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire fsc_pkg::fsc_item_t item,
	output logic                   ev_push,
	output fsc_pkg::fsc_event_t    ev
);
	import fsc_pkg::*;

	logic [OFF_W-1:0] offset_q;
	logic [7:0]       recent_q [4];
	logic [7:0]       w0, w1, w2, w3, w4;
	logic [OFF_W-1:0] next_off;

	assign w4 = item.data_byte;
	assign w3 = recent_q[0];
	assign w2 = recent_q[1];
	assign w1 = recent_q[2];
	assign w0 = recent_q[3];
	assign next_off = offset_q + OFF_W'(1);

	always_comb begin
		ev = '0;
		ev.next_offset = next_off;
		ev.last_byte   = item.end_of_image;
		ev.end_kind    = KIND_JPEG;
		ev.head_kind   = KIND_JPEG;
		ev.end_offset  = next_off;

		if (w3 == CH_FF && w4 == CH_D9) begin
			ev.end_hit  = 1'b1;
			ev.end_kind = KIND_JPEG;
		end else if (w0 == CH_PCT && w1 == CH_PCT && w2 == CH_E && w3 == CH_O && w4 == CH_F) begin
			ev.end_hit  = 1'b1;
			ev.end_kind = KIND_PDF;
		end else if (w1 == CH_P && w2 == CH_K && w3 == CH_05 && w4 == CH_06) begin
			ev.end_hit    = 1'b1;
			ev.end_kind   = KIND_ZIP;
			// next_off is the marker start plus its length
			ev.end_offset = next_off + ZIP_END_ADD;
		end

		if (w2 == CH_FF && w3 == CH_D8 && w4 == CH_FF) begin
			ev.head_hit  = 1'b1;
			ev.head_kind = KIND_JPEG;
			ev.head_len  = JPEG_HEAD_LEN;
		end else if (w0 == CH_PCT && w1 == CH_P && w2 == CH_D && w3 == CH_F && w4 == CH_DASH) begin
			ev.head_hit  = 1'b1;
			ev.head_kind = KIND_PDF;
			ev.head_len  = PDF_HEAD_LEN;
		end else if (w1 == CH_P && w2 == CH_K && w3 == CH_03 && w4 == CH_04) begin
			ev.head_hit  = 1'b1;
			ev.head_kind = KIND_ZIP;
			ev.head_len  = ZIP_HEAD_LEN;
		end
		ev.head_start = next_off - OFF_W'(ev.head_len);
	end

	// Bytes that neither mark nor end the image only advance the window
	assign ev_push = accept && (ev.end_hit || ev.head_hit || item.end_of_image);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			for (int i = 0; i < 4; i++) recent_q[i] <= '0;
		end else if (accept) begin
			if (item.end_of_image) begin
				offset_q <= '0;
				for (int i = 0; i < 4; i++) recent_q[i] <= '0;
			end else begin
				offset_q    <= next_off;
				recent_q[0] <= item.data_byte;
				recent_q[1] <= recent_q[0];
				recent_q[2] <= recent_q[1];
				recent_q[3] <= recent_q[2];
			end
		end
	end

endmodule

`default_nettype wire

[design/fsc_queue.sv]
// Short event queue between the scanner and the slot engine.
`default_nettype none

module fsc_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                wr_en,
	input  wire fsc_pkg::fsc_event_t wr_data,
	output logic                     full,
	input  wire logic                rd_en,
	output fsc_pkg::fsc_event_t      rd_data,
	output logic                     empty
);
	import fsc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	fsc_event_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr, do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(DEPTH - 1)) r = '0;
		else r = p + PTR_W'(1);
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= bump(wr_ptr_q);
			if (do_rd) rd_ptr_q <= bump(rd_ptr_q);
			if (do_wr && !do_rd) count_q <= count_q + CNT_W'(1);
			else if (do_rd && !do_wr) count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

`default_nettype wire

[design/fsc_slots.sv]
// Back end: candidate slot table, age ordering and result register.
`default_nettype none

module fsc_slots #(
	parameter int OPEN_SLOTS = 8
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_write,
	input  wire logic [fsc_pkg::CFG_W-1:0]  cfg_data,
	input  wire fsc_pkg::fsc_event_t        ev,
	input  wire logic                       ev_empty,
	output logic                            ev_pop,
	output fsc_pkg::fsc_result_t            result,
	output logic                            empty,
	input  wire logic                       pop
);
	import fsc_pkg::*;

	localparam int IDX_W = (OPEN_SLOTS > 1) ? $clog2(OPEN_SLOTS) : 1;

	logic [CFG_W-1:0]      max_len_q;
	logic [OPEN_SLOTS-1:0] valid_q;
	logic [OPEN_SLOTS-1:0] done_q;
	logic                  ovf_q;
	logic [OFF_W-1:0]      start_q [OPEN_SLOTS];
	fsc_kind_t             kind_q  [OPEN_SLOTS];
	// older_q[i][j]: slot i was opened before slot j
	logic [OPEN_SLOTS-1:0] older_q [OPEN_SLOTS];
	fsc_result_t           out_q;
	logic                  out_valid_q;

	logic [OFF_W-1:0]      age [OPEN_SLOTS];
	logic [OPEN_SLOTS-1:0] close_v, expire_v, remain_v, rem_v, sel_v;
	logic [IDX_W-1:0]      free_idx;
	logic                  any_free, want_open, open_ok, ovf_now;
	logic                  last, can_emit, emit, commit;
	logic [OFF_W-1:0]      start_sel;

	always_comb begin
		for (int i = 0; i < OPEN_SLOTS; i++) begin
			age[i] = ev.next_offset - start_q[i];
			close_v[i] = valid_q[i] && ev.end_hit && (kind_q[i] == ev.end_kind) &&
				(age[i][OFF_W-1:CFG_W] == '0) && (age[i][CFG_W-1:0] <= max_len_q);
			expire_v[i] = valid_q[i] &&
				((age[i][OFF_W-1:CFG_W] != '0) || (age[i][CFG_W-1:0] >= max_len_q));
		end
	end

	assign remain_v  = valid_q & ~close_v & ~expire_v;
	assign want_open = ev.head_hit && (CFG_W'(ev.head_len) < max_len_q);

	// Lowest free slot after this byte's closes and expiries
	always_comb begin
		free_idx = '0;
		any_free = 1'b0;
		for (int i = OPEN_SLOTS - 1; i >= 0; i--) begin
			if (!remain_v[i]) begin
				free_idx = IDX_W'(i);
				any_free = 1'b1;
			end
		end
	end

	assign open_ok = want_open && any_free;
	assign ovf_now = want_open && !any_free;

	// Oldest of the closing slots not yet reported
	assign rem_v = close_v & ~done_q;
	always_comb begin
		for (int i = 0; i < OPEN_SLOTS; i++) begin
			sel_v[i] = rem_v[i];
			for (int j = 0; j < OPEN_SLOTS; j++) begin
				if (j != i && rem_v[j] && !older_q[i][j]) sel_v[i] = 1'b0;
			end
		end
	end

	always_comb begin
		start_sel = '0;
		for (int i = 0; i < OPEN_SLOTS; i++) begin
			if (sel_v[i]) start_sel = start_sel | start_q[i];
		end
	end

	assign last     = ((rem_v & ~sel_v) == '0);
	assign can_emit = !out_valid_q || pop;
	assign emit     = !ev_empty && (rem_v != '0) && can_emit;
	// Table update lands with the last result of the item, or at once if none
	assign commit   = !ev_empty && ((rem_v == '0) || (emit && last));
	assign ev_pop   = commit;

	assign result = out_q;
	assign empty  = !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q   <= MAX_LEN_RESET;
			valid_q     <= '0;
			done_q      <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) max_len_q <= cfg_data;
			if (commit) begin
				done_q <= '0;
				if (ovf_now) ovf_q <= 1'b1;
				if (ev.last_byte) valid_q <= '0;
				else if (open_ok) valid_q <= remain_v | (OPEN_SLOTS'(1) << free_idx);
				else valid_q <= remain_v;
			end else if (emit) begin
				done_q <= done_q | sel_v;
			end
			if (emit) out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit && open_ok) begin
			start_q[free_idx] <= ev.head_start;
			kind_q[free_idx]  <= ev.head_kind;
			for (int j = 0; j < OPEN_SLOTS; j++) begin
				if (IDX_W'(j) == free_idx) older_q[j] <= '0;
				else older_q[j][free_idx] <= 1'b1;
			end
		end
		if (emit) begin
			out_q.start_offset  <= start_sel;
			out_q.end_offset    <= ev.end_offset;
			out_q.file_kind     <= ev.end_kind;
			out_q.last_of_run   <= last;
			out_q.overflow_seen <= ovf_q | ovf_now;
		end
	end

endmodule

`default_nettype wire

[design/file_signature_carver.sv]
// File signature carver: one image byte per cycle in, one carved candidate per result out.
// A scanner keeps the byte offset and the last four bytes, and passes each byte that
// completes a header or end marker, or ends the image, into a QUEUE_DEPTH-entry queue.
// The slot engine takes one queued item per cycle; an item that closes k candidates
// holds it until its k results are out, one result per cycle while the output is free
// or popped, oldest candidate first. Input takes one byte per cycle while the queue has
// room; full rises only when closing bursts outrun the queue. Results wait in a single
// output register that refills on the cycle it is popped; no clearing pass follows reset.
`default_nettype none

module file_signature_carver #(
	parameter int OPEN_SLOTS  = 8,
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      push,
	output logic                           full,
	input  wire fsc_pkg::fsc_item_t        item,
	output logic                           empty,
	input  wire logic                      pop,
	output fsc_pkg::fsc_result_t           result,
	input  wire logic                      cfg_write,
	input  wire logic [fsc_pkg::CFG_W-1:0] cfg_data
);
	import fsc_pkg::*;

	logic       accept;
	logic       ev_push, ev_pop, ev_empty;
	fsc_event_t ev_in, ev_out;

	assign accept = push && !full;

	fsc_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.item    (item),
		.ev_push (ev_push),
		.ev      (ev_in)
	);

	fsc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (ev_push),
		.wr_data (ev_in),
		.full    (full),
		.rd_en   (ev_pop),
		.rd_data (ev_out),
		.empty   (ev_empty)
	);

	fsc_slots #(
		.OPEN_SLOTS (OPEN_SLOTS)
	) u_slots (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_data  (cfg_data),
		.ev        (ev_out),
		.ev_empty  (ev_empty),
		.ev_pop    (ev_pop),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

`default_nettype wire
